FILE: rtl/core/tsrb_pkg.sv
// Shared types and constants for the timestamp reorder buffer.
`default_nettype none

package tsrb_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int STAMP_BITS  = 48;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int LAG_W       = 8;
    localparam int LAG_CMP_W   = (CNT_W > LAG_W) ? CNT_W : LAG_W;
    localparam int FIELD_W     = 48;
    localparam int BUF_W       = 6;
    localparam int PROB_W      = 32;
    localparam int IN_W        = 112;
    localparam int OUT_W       = 128;

    typedef logic [STAMP_BITS-1:0] t_stamp;
    typedef logic [ADDR_W-1:0]     t_addr;
    typedef logic [CNT_W-1:0]      t_cnt;
    typedef logic [LAG_CMP_W-1:0]  t_lag_cmp;
    typedef logic [FIELD_W-1:0]    t_field;
    typedef logic [BUF_W-1:0]      t_buf;
    typedef logic [PROB_W-1:0]     t_prob;

    localparam t_prob PROB_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TRIM,
        ST_SCAN,
        ST_PLACE,
        ST_POP,
        ST_POP_RD,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

FILE: rtl/core/timestamp_reorder_buffer.sv
// Timestamp reorder buffer: sorted store, sequencer and problem counters.
`default_nettype none

// One item is taken at a time; tready is high only while the block is idle.
// An accepted item passes the trim step, the pop step and the finishing
// step before its result is loaded, and the block is idle again before the
// next item is accepted. When the packet stamp is inserted, a walk compares
// it against stored entries (at most STORE_DEPTH-1, as a full store takes no
// insert) before a place step writes it. A pop read step follows the pop step
// when a frame pops a stamp. The insertion walk reads and moves one entry of
// the single store memory per cycle, starting at the tail. A finished result
// waits in the output register while the next item is accepted, and the
// finishing step holds while an earlier result still waits there.
// correct_enable resets to 1; the user must write it by i_cfg_wr_en /
// i_cfg_wr_data only while the block is idle; the block does not enforce it.
module timestamp_reorder_buffer (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_wr_en,
    input  wire                         i_cfg_wr_data,   // correct_enable
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // in_stamp_valid, in_stamp[47:0], lag_valid, lag_frames[7:0], frame_out,
    // codec_stamp_valid, codec_stamp[47:0], zero pad
    input  wire  [tsrb_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // out_frame, out_stamp_valid, out_stamp[47:0], overflow_flag,
    // underflow_flag, buffered_now[5:0], codec_problems[31:0],
    // sorted_problems[31:0], zero pad
    output logic [tsrb_pkg::OUT_W-1:0]  m_axis_tdata
);

    tsrb_pkg::t_state r_state, n_state;

    logic             r_correct;
    tsrb_pkg::t_cnt   r_count;
    tsrb_pkg::t_addr  r_k;
    logic             r_overflow;
    logic             r_popped;

    // latched item
    logic             r_in_valid;
    tsrb_pkg::t_stamp r_stamp;
    logic             r_lag_valid;
    logic [tsrb_pkg::LAG_W-1:0] r_lag;
    logic             r_frame;
    logic             r_cvalid;
    tsrb_pkg::t_stamp r_cstamp;

    logic             r_last_cvalid;
    tsrb_pkg::t_stamp r_last_cstamp;
    logic             r_last_svalid;
    tsrb_pkg::t_stamp r_last_sstamp;
    tsrb_pkg::t_prob  r_codec_prob;
    tsrb_pkg::t_prob  r_sorted_prob;

    logic             r_out_valid;
    logic [tsrb_pkg::OUT_W-1:0] r_out_data;

    // store memory
    tsrb_pkg::t_stamp r_mem [tsrb_pkg::STORE_DEPTH];
    tsrb_pkg::t_stamp r_rd_data;
    logic             rd_en;
    tsrb_pkg::t_addr  rd_addr;
    logic             mem_we;
    tsrb_pkg::t_addr  mem_waddr;
    tsrb_pkg::t_stamp mem_wdata;

    logic             in_fire;
    logic             ins;
    logic             trim_hit;
    tsrb_pkg::t_cnt   trim_count;
    logic             full;
    logic             less;
    logic             pop_req;
    logic             out_free;

    // result values formed in the finishing state
    logic             new_svalid;
    tsrb_pkg::t_stamp new_sstamp;
    logic             codec_bad;
    logic             sorted_bad;
    logic             underflow;
    tsrb_pkg::t_prob  codec_next;
    tsrb_pkg::t_prob  sorted_next;
    logic             out_svalid;
    tsrb_pkg::t_field out_stamp;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign ins      = r_correct && r_in_valid;
    assign trim_hit = ins && r_lag_valid &&
                      (tsrb_pkg::t_lag_cmp'(r_lag) <= tsrb_pkg::t_lag_cmp'(r_count));
    assign trim_count = trim_hit ? tsrb_pkg::t_cnt'(r_lag) : r_count;
    assign full     = (trim_count >= tsrb_pkg::t_cnt'(tsrb_pkg::STORE_DEPTH));
    assign less     = ($signed(r_rd_data) < $signed(r_stamp));
    assign pop_req  = r_frame && r_correct && (r_count != '0);
    assign out_free = !r_out_valid || m_axis_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tsrb_pkg::ST_IDLE: begin
                if (s_axis_tvalid) n_state = tsrb_pkg::ST_TRIM;
            end
            tsrb_pkg::ST_TRIM: begin
                if (ins && !full) begin
                    n_state = (trim_count == '0) ? tsrb_pkg::ST_PLACE : tsrb_pkg::ST_SCAN;
                end else begin
                    n_state = tsrb_pkg::ST_POP;
                end
            end
            tsrb_pkg::ST_SCAN: begin
                if (!less || r_k == tsrb_pkg::t_addr'(1)) n_state = tsrb_pkg::ST_PLACE;
            end
            tsrb_pkg::ST_PLACE:  n_state = tsrb_pkg::ST_POP;
            tsrb_pkg::ST_POP:    n_state = pop_req ? tsrb_pkg::ST_POP_RD : tsrb_pkg::ST_DONE;
            tsrb_pkg::ST_POP_RD: n_state = tsrb_pkg::ST_DONE;
            tsrb_pkg::ST_DONE: begin
                if (out_free) n_state = tsrb_pkg::ST_IDLE;
            end
            default:             n_state = tsrb_pkg::ST_IDLE;
        endcase
    end

    // memory and handshake controls
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        mem_we        = 1'b0;
        mem_waddr     = r_k;
        mem_wdata     = r_stamp;
        case (r_state)
            tsrb_pkg::ST_IDLE: s_axis_tready = 1'b1;
            tsrb_pkg::ST_TRIM: begin
                // fetch the tail entry to start the walk
                rd_en   = ins && !full && (trim_count != '0);
                rd_addr = tsrb_pkg::t_addr'(trim_count - tsrb_pkg::t_cnt'(1));
            end
            tsrb_pkg::ST_SCAN: begin
                if (less) begin
                    // move the entry one place towards the tail, fetch the next
                    mem_we    = 1'b1;
                    mem_wdata = r_rd_data;
                    rd_en     = (r_k != tsrb_pkg::t_addr'(1));
                    rd_addr   = r_k - tsrb_pkg::t_addr'(2);
                end
            end
            tsrb_pkg::ST_PLACE: mem_we = 1'b1;
            tsrb_pkg::ST_POP: begin
                rd_en   = pop_req;
                rd_addr = tsrb_pkg::t_addr'(r_count - tsrb_pkg::t_cnt'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (rd_en)  r_rd_data <= r_mem[rd_addr];
    end

    // result of the frame part
    always_comb begin
        new_svalid = r_last_svalid;
        new_sstamp = r_last_sstamp;
        underflow  = 1'b0;
        if (r_frame && r_correct) begin
            new_svalid = r_popped;
            new_sstamp = r_popped ? r_rd_data : '0;
            underflow  = !r_popped;
        end
        codec_bad  = !r_cvalid ||
                     (r_last_cvalid && ($signed(r_cstamp) <= $signed(r_last_cstamp)));
        sorted_bad = !new_svalid ||
                     (r_last_svalid && ($signed(new_sstamp) <= $signed(r_last_sstamp)));
        codec_next  = r_codec_prob;
        sorted_next = r_sorted_prob;
        if (r_frame && codec_bad && r_codec_prob != tsrb_pkg::PROB_MAX) begin
            codec_next = r_codec_prob + tsrb_pkg::t_prob'(1);
        end
        if (r_frame && sorted_bad && r_sorted_prob != tsrb_pkg::PROB_MAX) begin
            sorted_next = r_sorted_prob + tsrb_pkg::t_prob'(1);
        end
        out_svalid = r_frame && new_svalid;
        out_stamp  = out_svalid ? tsrb_pkg::t_field'(new_sstamp) : '0;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tsrb_pkg::ST_IDLE;
            r_correct     <= 1'b1;
            r_count       <= '0;
            r_last_cvalid <= 1'b0;
            r_last_svalid <= 1'b0;
            r_codec_prob  <= '0;
            r_sorted_prob <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_correct <= i_cfg_wr_data;
            // load a finished item, else drop the one the sink has taken
            if (r_state == tsrb_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                tsrb_pkg::ST_TRIM:  r_count <= trim_count;
                tsrb_pkg::ST_PLACE: r_count <= r_count + tsrb_pkg::t_cnt'(1);
                tsrb_pkg::ST_POP: begin
                    if (pop_req) r_count <= r_count - tsrb_pkg::t_cnt'(1);
                end
                tsrb_pkg::ST_DONE: begin
                    if (out_free) begin
                        if (r_frame) begin
                            r_last_cvalid <= r_cvalid;
                            r_last_svalid <= new_svalid;
                            r_codec_prob  <= codec_next;
                            r_sorted_prob <= sorted_next;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_valid  <= s_axis_tdata[0];
            r_stamp     <= tsrb_pkg::t_stamp'(s_axis_tdata[48:1]);
            r_lag_valid <= s_axis_tdata[49];
            r_lag       <= s_axis_tdata[57:50];
            r_frame     <= s_axis_tdata[58];
            r_cvalid    <= s_axis_tdata[59];
            r_cstamp    <= tsrb_pkg::t_stamp'(s_axis_tdata[107:60]);
            r_popped    <= 1'b0;
        end
        case (r_state)
            tsrb_pkg::ST_TRIM: begin
                r_overflow <= ins && full;
                r_k        <= tsrb_pkg::t_addr'(trim_count);
            end
            tsrb_pkg::ST_SCAN: begin
                if (less) r_k <= r_k - tsrb_pkg::t_addr'(1);
            end
            tsrb_pkg::ST_POP: r_popped <= pop_req;
            tsrb_pkg::ST_DONE: begin
                if (out_free) begin
                    if (r_frame) begin
                        r_last_cstamp <= r_cvalid ? r_cstamp : '0;
                        r_last_sstamp <= new_sstamp;
                    end
                    r_out_data <= {6'b0, sorted_next, codec_next,
                                   tsrb_pkg::t_buf'(r_count), underflow, r_overflow,
                                   out_stamp, out_svalid, r_frame};
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // the store never holds more than its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= tsrb_pkg::t_cnt'(tsrb_pkg::STORE_DEPTH))
        else $error("stored count beyond store depth");

    // an accepted item always starts with the trim step
    a_accept_trim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == tsrb_pkg::ST_TRIM)
        else $error("accepted item did not enter trim");

    // overflow is only flagged with a full store
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tsrb_pkg::ST_POP && r_overflow) |->
            r_count == tsrb_pkg::t_cnt'(tsrb_pkg::STORE_DEPTH))
        else $error("overflow flagged with room in the store");

    // the walk leaves before the insertion point reaches the head
    a_scan_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tsrb_pkg::ST_SCAN |-> r_k != '0)
        else $error("insertion walk ran past the head");

    // a pop reads only when entries are held
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == tsrb_pkg::ST_POP_RD |-> $past(r_count) != '0)
        else $error("pop from an empty store");

endmodule

`default_nettype wire
